// File: hw/rtl/bmpc_pkg.sv
`default_nettype none

package bmpc_pkg;

    localparam int MODE_W  = 2;
    localparam int VALUE_W = 8;
    localparam int POS_W   = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADJUST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSAL_PAUSE = 1'd1;

    localparam logic [CFG_W-1:0] STEP_INTERVAL_RESET  = 16'd200;
    localparam logic [CFG_W-1:0] REVERSAL_PAUSE_RESET = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] step_interval_ms;
        logic [CFG_W-1:0] reversal_pause_ms;
    } cfg_t;

    typedef struct packed {
        logic             relay_power;
        logic             relay_direction;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] target;
        logic             report_valid;
        logic             pausing;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bmpc_ctrl.sv
`default_nettype none

module bmpc_ctrl #(
    parameter int POSITION_MAX = 100
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            item_fire,
    input  wire logic [bmpc_pkg::MODE_W-1:0]     item_mode,
    input  wire logic signed [bmpc_pkg::VALUE_W-1:0] item_value,
    input  wire bmpc_pkg::cfg_t                  cfg,
    output bmpc_pkg::result_t                    result
);
    import bmpc_pkg::*;

    localparam logic [1:0] MOT_DOWN = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_STOP = 2'd2;

    localparam logic signed [9:0] MAX_S   = 10'(POSITION_MAX);
    localparam logic [POS_W-1:0]  MAX_POS = POS_W'(POSITION_MAX);

    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] target_reg, target_next;
    logic [1:0]       motion_reg, motion_next;
    logic             pause_reg, pause_next;
    logic [CFG_W-1:0] pause_elapsed_reg, pause_elapsed_next;
    logic [CFG_W-1:0] step_elapsed_reg, step_elapsed_next;
    logic             power_reg, power_next;
    logic             direction_reg, direction_next;
    logic             report;
    logic             running;
    logic             up;
    logic signed [9:0] cand;

    function automatic logic is_tenth(input logic [POS_W-1:0] p);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  tens;
        prod = {8'b0, p} * 15'd205;
        q    = prod[14:11];
        tens = {3'b0, q} * 7'd10;
        return tens == p;
    endfunction

    always_comb begin
        position_next      = position_reg;
        target_next        = target_reg;
        motion_next        = motion_reg;
        pause_next         = pause_reg;
        pause_elapsed_next = pause_elapsed_reg;
        step_elapsed_next  = step_elapsed_reg;
        power_next         = power_reg;
        direction_next     = direction_reg;
        report             = 1'b0;
        running            = 1'b1;
        up                 = target_reg > position_reg;
        cand               = {{2{item_value[7]}}, item_value};
        if (item_mode == MODE_ADJUST) begin
            cand = $signed({3'b0, target_reg}) + {{2{item_value[7]}}, item_value};
        end

        unique case (item_mode)
            MODE_TICK: begin
                if (step_elapsed_reg < cfg.step_interval_ms) begin
                    step_elapsed_next = step_elapsed_reg + 1'b1;
                end
                if (pause_reg) begin
                    if (pause_elapsed_reg != '1) begin
                        pause_elapsed_next = pause_elapsed_reg + 1'b1;
                    end
                    if (pause_elapsed_next >= cfg.reversal_pause_ms) begin
                        pause_next = 1'b0;
                    end else begin
                        running = 1'b0;
                    end
                end
                if (running) begin
                    if (position_reg != target_reg) begin
                        if ((motion_reg == MOT_UP && !up) || (motion_reg == MOT_DOWN && up)) begin
                            power_next         = 1'b0;
                            motion_next        = MOT_STOP;
                            pause_next         = 1'b1;
                            pause_elapsed_next = '0;
                        end else if (step_elapsed_next >= cfg.step_interval_ms) begin
                            step_elapsed_next = '0;
                            if (up) begin
                                motion_next    = MOT_UP;
                                direction_next = 1'b1;
                                position_next  = position_reg + 1'b1;
                            end else begin
                                motion_next    = MOT_DOWN;
                                direction_next = 1'b0;
                                position_next  = position_reg - 1'b1;
                            end
                            power_next = 1'b1;
                            report     = is_tenth(position_next) || (position_next == target_reg);
                        end
                    end else if (motion_reg != MOT_STOP) begin
                        power_next     = 1'b0;
                        direction_next = 1'b0;
                        motion_next    = MOT_STOP;
                        report         = 1'b1;
                    end
                end
            end
            MODE_SET, MODE_ADJUST: begin
                if (cand[9]) begin
                    target_next = '0;
                end else if (cand > MAX_S) begin
                    target_next = MAX_POS;
                end else begin
                    target_next = cand[POS_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg      <= '0;
            target_reg        <= '0;
            motion_reg        <= MOT_STOP;
            pause_reg         <= 1'b0;
            pause_elapsed_reg <= '0;
            step_elapsed_reg  <= '0;
            power_reg         <= 1'b0;
            direction_reg     <= 1'b0;
        end else if (item_fire) begin
            position_reg      <= position_next;
            target_reg        <= target_next;
            motion_reg        <= motion_next;
            pause_reg         <= pause_next;
            pause_elapsed_reg <= pause_elapsed_next;
            step_elapsed_reg  <= step_elapsed_next;
            power_reg         <= power_next;
            direction_reg     <= direction_next;
        end
    end

    assign result.relay_power     = power_next;
    assign result.relay_direction = direction_next;
    assign result.position        = position_next;
    assign result.target          = target_next;
    assign result.report_valid    = report;
    assign result.pausing         = pause_next;

    a_position_range: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= MAX_POS)
        else $error("Tracked position is beyond the travel range.");

    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        target_reg <= MAX_POS)
        else $error("Target is beyond the travel range.");

    a_pause_unpowered: assert property (@(posedge aclk) disable iff (!aresetn)
        pause_reg |-> !power_reg)
        else $error("Motor is powered during the reversal dead time.");

    a_stop_unpowered: assert property (@(posedge aclk) disable iff (!aresetn)
        motion_reg == MOT_STOP |-> !power_reg)
        else $error("Motor is powered while stopped.");

    a_step_single: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_fire |=> $stable(position_reg) && $stable(target_reg))
        else $error("Position or target changed without an item.");

endmodule

`default_nettype wire

// File: hw/rtl/blind_motor_position_controller.sv
// Blind motor position controller.
// The input channel (s_valid, s_ready, s_mode, s_value) carries one beat per
// item: a one millisecond tick, an absolute target, or a signed target delta.
// The result channel (m_valid, m_ready, m_*) returns exactly one beat per
// input beat, in order, with the relay levels, position, target, a report
// flag and the reversal dead time flag as they stand after that item.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes the step
// interval (index 0) and the reversal pause (index 1) in milliseconds; write
// it only while no beat is in flight.
// An accepted beat is held in an input register until the output register is free
// or being drained; then the position logic updates the state and loads the output
// register. One beat is taken every cycle while the receiver does not stall.
// When the receiver stalls, the result holds in the output register, the next
// beat waits in the input register, and s_ready falls once both are full.
// Synchronous reset clears the motor state including both relay levels, restores
// the interval to 200 ms and the pause to 1000 ms, and empties both registers.
`default_nettype none

module blind_motor_position_controller #(
    parameter int POSITION_MAX = 100
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [bmpc_pkg::MODE_W-1:0]         s_mode,
    input  wire logic signed [bmpc_pkg::VALUE_W-1:0] s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_relay_power,
    output logic                                     m_relay_direction,
    output logic [bmpc_pkg::POS_W-1:0]               m_position,
    output logic [bmpc_pkg::POS_W-1:0]               m_target,
    output logic                                     m_report_valid,
    output logic                                     m_pausing,
    input  wire logic                                cfg_we,
    input  wire logic [bmpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bmpc_pkg::CFG_W-1:0]          cfg_wdata
);
    import bmpc_pkg::*;

    logic                       in_valid_reg;
    logic [MODE_W-1:0]          in_mode_reg;
    logic signed [VALUE_W-1:0]  in_value_reg;
    logic                       m_valid_reg;
    result_t                    m_result_reg;
    result_t                    result;
    cfg_t                       cfg_reg;
    logic                       advance;
    logic                       fire;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign fire    = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg  <= s_mode;
            in_value_reg <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_interval_ms  <= STEP_INTERVAL_RESET;
            cfg_reg.reversal_pause_ms <= REVERSAL_PAUSE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STEP_INTERVAL:  cfg_reg.step_interval_ms  <= cfg_wdata;
                REG_REVERSAL_PAUSE: cfg_reg.reversal_pause_ms <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bmpc_ctrl #(
        .POSITION_MAX(POSITION_MAX)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (fire),
        .item_mode (in_mode_reg),
        .item_value(in_value_reg),
        .cfg       (cfg_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_result_reg <= result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_relay_power     = m_result_reg.relay_power;
    assign m_relay_direction = m_result_reg.relay_direction;
    assign m_position        = m_result_reg.position;
    assign m_target          = m_result_reg.target;
    assign m_report_valid    = m_result_reg.report_valid;
    assign m_pausing         = m_result_reg.pausing;

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("A waiting beat was lost while the output stalled.");

    a_fill_output: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("A processed beat did not reach the output register.");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("Input is blocked although the input register is empty.");

endmodule

`default_nettype wire
